/* hw/rtl/lskv_pkg.sv */
// Types, codes and widths shared by the key/value table cells and top level.
// No dependencies.
`default_nettype none

package lskv_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CNT_OUT_W  = 7;
    localparam int CAPACITY_D = 64;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd             command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        logic                 found;
        t_status              status;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic             valid;
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             hit;
        logic [VAL_W-1:0] rvalue;
    } t_token;

endpackage

`default_nettype wire

/* hw/rtl/linear_search_key_value_table.sv */
// Top level of the linear-search key/value table: a row of lskv_cell entries,
// the entry count and the result register. Depends on lskv_pkg, lskv_cell.
//
//   channel   direction  handshake                 word
//   input     in         i_in_valid / o_in_ready   i_in_word  (t_in_word)
//   output    out        o_out_valid / i_out_ready o_out_word (t_out_word)
//
// Each command rides a token through all CAPACITY cells, one cell a cycle unless
// the row holds; the result is registered when the token leaves the last cell,
// and no new word is taken until then.
// Reset is synchronous and empties the table; entry contents are not cleared.
// If the result register is still full when a token leaves the row, the row holds.
`default_nettype none

module linear_search_key_value_table #(
    parameter int CAPACITY = lskv_pkg::CAPACITY_D,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  lskv_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output lskv_pkg::t_out_word  o_out_word
);

    lskv_pkg::t_token           w_tok [CAPACITY];
    logic [lskv_pkg::KEY_W-1:0] w_key [CAPACITY];
    logic [lskv_pkg::VAL_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]        w_tok_valid;
    lskv_pkg::t_token           w_entry, w_exit;

    logic                r_busy, n_busy;
    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid, n_out_valid;
    lskv_pkg::t_out_word r_out_word, n_out_word;
    logic                w_accept, w_take, w_step, w_full;

    assign w_exit   = w_tok[CAPACITY-1];
    assign w_full   = r_count == CW'(CAPACITY);
    assign w_take   = w_exit.valid && (!r_out_valid || i_out_ready);
    assign w_step   = !w_exit.valid || w_take;
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_entry        = '0;
        w_entry.valid  = w_accept;
        w_entry.cmd    = i_in_word.command;
        w_entry.key    = i_in_word.key;
        w_entry.value  = i_in_word.write_value;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lskv_pkg::t_token           w_in;
        logic [lskv_pkg::KEY_W-1:0] w_nk;
        logic [lskv_pkg::VAL_W-1:0] w_nv;

        if (g == 0) begin : g_first
            assign w_in = w_entry;
        end else begin : g_mid
            assign w_in = w_tok[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_nk = '0;
            assign w_nv = '0;
        end else begin : g_inner
            assign w_nk = w_key[g+1];
            assign w_nv = w_val[g+1];
        end

        lskv_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (w_step),
            .i_count      (r_count),
            .i_tok        (w_in),
            .i_next_key   (w_nk),
            .i_next_value (w_nv),
            .o_key        (w_key[g]),
            .o_value      (w_val[g]),
            .o_tok        (w_tok[g])
        );

        assign w_tok_valid[g] = w_tok[g].valid;
    end

    always_comb begin
        n_busy      = r_busy;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_busy = 1'b1;
        end

        if (w_take) begin
            n_busy                 = 1'b0;
            n_out_valid            = 1'b1;
            n_out_word.found       = w_exit.hit;
            n_out_word.status      = lskv_pkg::ST_OK;
            n_out_word.read_value  = '0;
            case (w_exit.cmd)
                lskv_pkg::CMD_READ: begin
                    n_out_word.read_value = w_exit.rvalue;
                end
                lskv_pkg::CMD_WRITE: begin
                    if (!w_exit.hit) begin
                        if (w_full) begin
                            n_out_word.status = lskv_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end
                end
                lskv_pkg::CMD_DELETE: begin
                    if (w_exit.hit) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        n_out_word.status = lskv_pkg::ST_ABSENT;
                    end
                end
                lskv_pkg::CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            n_out_word.entry_count = lskv_pkg::CNT_OUT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one token in the cell row");

    a_busy_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (|w_tok_valid))
        else $error("busy flag disagrees with token presence");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (o_out_word.entry_count == lskv_pkg::CNT_OUT_W'(r_count)))
        else $error("reported entry count differs from stored count");

endmodule

`default_nettype wire

/* hw/rtl/lskv_cell.sv */
// One table entry: key and value registers plus the token stage that passes
// the current command on to the next cell. Depends on lskv_pkg.
`default_nettype none

module lskv_cell #(
    parameter int CAPACITY = lskv_pkg::CAPACITY_D,
    parameter int INDEX    = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_step,
    input  wire [CW-1:0]                i_count,
    input  lskv_pkg::t_token            i_tok,
    input  wire [lskv_pkg::KEY_W-1:0]   i_next_key,
    input  wire [lskv_pkg::VAL_W-1:0]   i_next_value,
    output logic [lskv_pkg::KEY_W-1:0]  o_key,
    output logic [lskv_pkg::VAL_W-1:0]  o_value,
    output lskv_pkg::t_token            o_tok
);

    logic [lskv_pkg::KEY_W-1:0] r_key, n_key;
    logic [lskv_pkg::VAL_W-1:0] r_value, n_value;
    lskv_pkg::t_token           r_tok, n_tok;
    logic                       w_live, w_match, w_append, w_shift;

    always_comb begin
        w_live   = CW'(INDEX) < i_count;
        w_match  = i_tok.valid && w_live && !i_tok.hit &&
                   (i_tok.cmd != lskv_pkg::CMD_CLEAR) && (r_key == i_tok.key);
        w_append = i_tok.valid && (i_tok.cmd == lskv_pkg::CMD_WRITE) && !i_tok.hit &&
                   (CW'(INDEX) == i_count);
        w_shift  = i_tok.valid && (i_tok.cmd == lskv_pkg::CMD_DELETE) &&
                   (i_tok.hit || w_match);

        n_key   = r_key;
        n_value = r_value;
        if (w_shift) begin
            n_key   = i_next_key;
            n_value = i_next_value;
        end else if (w_append) begin
            n_key   = i_tok.key;
            n_value = i_tok.value;
        end else if (w_match && (i_tok.cmd == lskv_pkg::CMD_WRITE)) begin
            n_value = i_tok.value;
        end

        n_tok     = i_tok;
        n_tok.hit = i_tok.hit || w_match;
        if (w_match) begin
            n_tok.rvalue = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_key   <= n_key;
            r_value <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_step) begin
            r_tok <= n_tok;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire
